// ===== rtl/kdtq_pkg.sv =====
package kdtq_pkg;

   // Table size and field widths.
   localparam int SLOTS     = 16;
   localparam int IDX_W     = $clog2(SLOTS);
   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int TIME_BITS = 48;
   localparam int KEY_W     = 16;
   localparam int CLS_W     = 8;
   localparam int FUNC_W    = 3;

   // Delay reported when no timer is pending: 100000 s in microseconds.
   localparam logic [TIME_BITS-1:0] EMPTY_DELAY = TIME_BITS'(64'd100000000000);

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_SET_REPLACE = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_SET_DISCARD = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE_KEY  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE_CLS  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_QUERY_KEY   = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_QUERY_CLS   = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_TICK        = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED      = 3'd7;

   // Running summary handed from one cell to the next.
   typedef struct packed {
      logic                 key_hit;
      logic [IDX_W-1:0]     key_idx;
      logic [IDX_W-1:0]     key_rank;
      logic                 cls_hit;
      logic [IDX_W-1:0]     cls_idx;
      logic [IDX_W-1:0]     cls_rank;
      logic                 free_hit;
      logic [IDX_W-1:0]     free_idx;
      logic [CNT_W-1:0]     cnt;
      logic                 best_hit;
      logic [IDX_W-1:0]     best_idx;
      logic [IDX_W-1:0]     best_rank;
      logic [TIME_BITS-1:0] best_exp;
      logic [KEY_W-1:0]     best_key;
      logic [CLS_W-1:0]     best_cls;
   } carry_type;

   // Command broadcast from the sequencer to every cell.
   typedef struct packed {
      logic                 unlink;
      logic [IDX_W-1:0]     unlink_idx;
      logic [IDX_W-1:0]     unlink_rank;
      logic                 wr;
      logic                 wr_keep;
      logic [IDX_W-1:0]     wr_idx;
      logic [IDX_W-1:0]     wr_rank;
      logic [KEY_W-1:0]     key;
      logic [CLS_W-1:0]     cls;
      logic [TIME_BITS-1:0] expiry;
   } cmd_type;

endpackage

// ===== rtl/kdtq_cell.sv =====
module kdtq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [kdtq_pkg::IDX_W-1:0] idx,
   input  kdtq_pkg::cmd_type     cmd,
   input  kdtq_pkg::carry_type   carry_i,
   output kdtq_pkg::carry_type   carry_o
);
   import kdtq_pkg::*;

   logic                 valid_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [CLS_W-1:0]     cls_ff;
   logic [TIME_BITS-1:0] exp_ff;
   logic [IDX_W-1:0]     rank_ff;
   carry_type            carry_ff, carry_in;

   // Slot state: a write takes the slot, otherwise an unlink closes the age gap.
   // A replace unlinks and rewrites the same slot, so the write covers it.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         if (cmd.wr && idx == cmd.wr_idx) begin
            valid_ff <= 1'b1;
            rank_ff  <= cmd.wr_rank;
            exp_ff   <= cmd.expiry;
            if (!cmd.wr_keep) begin
               key_ff <= cmd.key;
               cls_ff <= cmd.cls;
            end
         end else if (cmd.unlink && valid_ff) begin
            if (idx == cmd.unlink_idx) begin
               valid_ff <= 1'b0;
            end else if (rank_ff > cmd.unlink_rank) begin
               rank_ff <= rank_ff - 1'b1;
            end
         end
      end
   end

   // Fold this slot into the running summary.
   always_comb begin
      carry_in = carry_i;
      if (valid_ff) begin
         carry_in.cnt = carry_i.cnt + 1'b1;
         if (!carry_i.key_hit && key_ff == cmd.key) begin
            carry_in.key_hit  = 1'b1;
            carry_in.key_idx  = idx;
            carry_in.key_rank = rank_ff;
         end
         if (!carry_i.cls_hit && cls_ff == cmd.cls) begin
            carry_in.cls_hit  = 1'b1;
            carry_in.cls_idx  = idx;
            carry_in.cls_rank = rank_ff;
         end
         if (!carry_i.best_hit || exp_ff < carry_i.best_exp ||
             (exp_ff == carry_i.best_exp && rank_ff < carry_i.best_rank)) begin
            carry_in.best_hit  = 1'b1;
            carry_in.best_idx  = idx;
            carry_in.best_rank = rank_ff;
            carry_in.best_exp  = exp_ff;
            carry_in.best_key  = key_ff;
            carry_in.best_cls  = cls_ff;
         end
      end else if (!carry_i.free_hit) begin
         carry_in.free_hit = 1'b1;
         carry_in.free_idx = idx;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
   end

   assign carry_o = carry_ff;

endmodule

// ===== rtl/keyed_deadline_timer_queue.sv =====
// Keyed deadline timer queue: a table of 16 pending timers.
// Requests arrive on the req_ channel (valid/stall): req_func selects set
// replace, set discard, remove by key, remove by class, query by key, query
// by class or tick. Each request gives exactly one response on the rsp_
// channel (valid/stall), held in an output register.
// The slots sit in a row of cells; a summary of the table (key and class
// matches, first free slot, count, earliest timer) moves one cell per cycle
// along the row. Set, remove key and query requests take one pass, a tick
// takes two passes when it pops a timer, and a remove by class takes one
// pass per removed timer plus one.
// One request is in work at a time; req_stall is high while it runs, but a
// new request is taken while the previous response still waits.
// If rsp_stall holds the response register, the block finishes the current
// request and then waits with its result until the register frees up.
// Reset empties the table and drops any pending response.
module keyed_deadline_timer_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [kdtq_pkg::FUNC_W-1:0]     req_func,
   input  logic [kdtq_pkg::KEY_W-1:0]      req_timer_key,
   input  logic [kdtq_pkg::CLS_W-1:0]      req_timer_class,
   input  logic [kdtq_pkg::TIME_BITS-1:0]  req_time_us,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_found,
   output logic                            rsp_table_full,
   output logic                            rsp_expired,
   output logic [kdtq_pkg::KEY_W-1:0]      rsp_expired_key,
   output logic [kdtq_pkg::CLS_W-1:0]      rsp_expired_class,
   output logic [kdtq_pkg::TIME_BITS-1:0]  rsp_next_delay_us
);
   import kdtq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 pass_ff, pass_in;
   logic [FUNC_W-1:0]    func_ff, func_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [CLS_W-1:0]     cls_ff, cls_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic                 found_ff, found_in;
   logic                 full_ff, full_in;
   logic                 exp_ff, exp_in;
   logic [KEY_W-1:0]     ekey_ff, ekey_in;
   logic [CLS_W-1:0]     ecls_ff, ecls_in;
   logic [TIME_BITS-1:0] delay_ff, delay_in;
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff, rsp_full_ff, rsp_exp_ff;
   logic [KEY_W-1:0]     rsp_ekey_ff;
   logic [CLS_W-1:0]     rsp_ecls_ff;
   logic [TIME_BITS-1:0] rsp_delay_ff;
   logic                 rsp_load;
   cmd_type              cmd;
   carry_type            chain [SLOTS+1];
   carry_type            last;

   // Row of slot cells with the summary entering at cell zero.
   assign chain[0] = '0;
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      kdtq_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .idx     (IDX_W'(i)),
         .cmd     (cmd),
         .carry_i (chain[i]),
         .carry_o (chain[i+1])
      );
   end
   assign last = chain[SLOTS];

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer: accept, wait for a settled pass, act, respond.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pass_in  = pass_ff;
      func_in  = func_ff;
      key_in   = key_ff;
      cls_in   = cls_ff;
      time_in  = time_ff;
      found_in = found_ff;
      full_in  = full_ff;
      exp_in   = exp_ff;
      ekey_in  = ekey_ff;
      ecls_in  = ecls_ff;
      delay_in = delay_ff;
      cmd        = '0;
      cmd.key    = key_ff;
      cmd.cls    = cls_ff;
      cmd.expiry = time_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               key_in   = req_timer_key;
               cls_in   = req_timer_class;
               time_in  = req_time_us;
               found_in = 1'b0;
               full_in  = 1'b0;
               exp_in   = 1'b0;
               ekey_in  = '0;
               ecls_in  = '0;
               delay_in = '0;
               cnt_in   = '0;
               pass_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff != CNT_W'(SLOTS)) begin
               cnt_in = cnt_ff + 1'b1;
            end else begin
               cnt_in   = '0;
               state_in = ST_DONE;
               case (func_ff)
                  FUNC_SET_REPLACE, FUNC_SET_DISCARD: begin
                     if (last.key_hit) begin
                        found_in = 1'b1;
                        if (func_ff == FUNC_SET_REPLACE) begin
                           cmd.unlink      = 1'b1;
                           cmd.unlink_idx  = last.key_idx;
                           cmd.unlink_rank = last.key_rank;
                           cmd.wr          = 1'b1;
                           cmd.wr_keep     = 1'b1;
                           cmd.wr_idx      = last.key_idx;
                           cmd.wr_rank     = IDX_W'(last.cnt - 1'b1);
                        end
                     end else if (last.free_hit) begin
                        cmd.wr      = 1'b1;
                        cmd.wr_idx  = last.free_idx;
                        cmd.wr_rank = IDX_W'(last.cnt);
                     end else begin
                        full_in = 1'b1;
                     end
                  end
                  FUNC_REMOVE_KEY: begin
                     if (last.key_hit) begin
                        found_in        = 1'b1;
                        cmd.unlink      = 1'b1;
                        cmd.unlink_idx  = last.key_idx;
                        cmd.unlink_rank = last.key_rank;
                     end
                  end
                  FUNC_REMOVE_CLS: begin
                     // Remove one matching timer per pass until none is left.
                     if (last.cls_hit) begin
                        found_in        = 1'b1;
                        cmd.unlink      = 1'b1;
                        cmd.unlink_idx  = last.cls_idx;
                        cmd.unlink_rank = last.cls_rank;
                        state_in        = ST_SCAN;
                     end
                  end
                  FUNC_QUERY_KEY: begin
                     found_in = last.key_hit;
                  end
                  FUNC_QUERY_CLS: begin
                     found_in = last.cls_hit;
                  end
                  FUNC_TICK: begin
                     if (!pass_ff && last.best_hit && last.best_exp < time_ff) begin
                        exp_in          = 1'b1;
                        ekey_in         = last.best_key;
                        ecls_in         = last.best_cls;
                        cmd.unlink      = 1'b1;
                        cmd.unlink_idx  = last.best_idx;
                        cmd.unlink_rank = last.best_rank;
                        pass_in         = 1'b1;
                        state_in        = ST_SCAN;
                     end else if (!last.best_hit) begin
                        delay_in = EMPTY_DELAY;
                     end else if (last.best_exp > time_ff) begin
                        delay_in = last.best_exp - time_ff;
                     end else begin
                        delay_in = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pass_ff  <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      key_ff   <= key_in;
      cls_ff   <= cls_in;
      time_ff  <= time_in;
      found_ff <= found_in;
      full_ff  <= full_in;
      exp_ff   <= exp_in;
      ekey_ff  <= ekey_in;
      ecls_ff  <= ecls_in;
      delay_ff <= delay_in;
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff <= found_ff;
         rsp_full_ff  <= full_ff;
         rsp_exp_ff   <= exp_ff;
         rsp_ekey_ff  <= ekey_ff;
         rsp_ecls_ff  <= ecls_ff;
         rsp_delay_ff <= delay_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_table_full    = rsp_full_ff;
   assign rsp_expired       = rsp_exp_ff;
   assign rsp_expired_key   = rsp_ekey_ff;
   assign rsp_expired_class = rsp_ecls_ff;
   assign rsp_next_delay_us = rsp_delay_ff;

`ifndef SYNTH
   // An accepted request always starts a pass over the table.
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_SCAN))
      else $error("accepted request did not start a pass");

   // A popped timer only comes from a tick, which never reports found or full.
   a_expired_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_expired) |-> (!rsp_found && !rsp_table_full))
      else $error("expired response also flags found or full");

   // A refused insert never reports the key as present.
   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> !rsp_found)
      else $error("full response also flags found");
`endif

endmodule
